// ===== hdl/longest_job_first_scheduler_macros.svh =====
`ifndef LONGEST_JOB_FIRST_SCHEDULER_MACROS_SVH
`define LONGEST_JOB_FIRST_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LJFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked outside reset.
`define LJFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hdl/ljfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ljfs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int ID_W                = 8;
    localparam int BURST_W             = 16;
    localparam int TICK_W              = 32;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } t_entry;

    // Broadcast from the controller to every cell of the queue.
    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctrl;

    typedef struct packed {
        t_status           status;
        logic              slot_busy;
        logic [ID_W-1:0]   slot_job;
        logic              job_done;
        logic [TICK_W-1:0] finish_tick;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ljfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ljfs_in_if;
    import ljfs_pkg::*;

    logic               valid;
    logic               ready;
    t_op                operation;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst_len;

    modport source (output valid, operation, job_id, burst_len, input ready);
    modport sink   (input valid, operation, job_id, burst_len, output ready);
endinterface

interface ljfs_out_if;
    import ljfs_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic              slot_busy;
    logic [ID_W-1:0]   slot_job;
    logic              job_done;
    logic [TICK_W-1:0] finish_tick;

    modport source (output valid, status, slot_busy, slot_job, job_done, finish_tick,
                    input ready);
    modport sink   (input valid, status, slot_busy, slot_job, job_done, finish_tick,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/ljfs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ljfs_cell (
    input  wire                  i_clk,
    input  ljfs_pkg::t_cell_ctrl i_ctrl,
    input  wire                  i_occ,
    input  wire                  i_prev_gt,
    input  ljfs_pkg::t_entry     i_prev_entry,
    input  ljfs_pkg::t_entry     i_next_entry,
    output logic                 o_gt,
    output ljfs_pkg::t_entry     o_entry
);
    import ljfs_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Strictly greater keeps equal bursts in arrival order.
    assign o_gt    = !i_occ || (i_ctrl.new_entry.burst > r_entry.burst);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert && o_gt) begin
            n_entry = i_prev_gt ? i_prev_entry : i_ctrl.new_entry;
        end else if (i_ctrl.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== hdl/longest_job_first_scheduler.sv =====
// A result is loaded into the output register on the clock edge at which its item transfers.
// Throughput: one item per cycle while ready is high; all cells compare and shift together.
// Input ready is high while the output register is empty or being drained.
// Reset (synchronous, active low) empties the queue, idles the server, zeroes the tick count.
// Queue cell contents are not cleared; cells beyond the fill count are never read.
`timescale 1ns / 1ps
`default_nettype none

`include "longest_job_first_scheduler_macros.svh"

module longest_job_first_scheduler #(
    parameter int QUEUE_DEPTH = ljfs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ljfs_in_if.sink    i_job,
    ljfs_out_if.source o_res
);
    import ljfs_pkg::*;

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_running;
    logic               n_running;
    logic [ID_W-1:0]    r_run_job;
    logic [ID_W-1:0]    n_run_job;
    logic [BURST_W-1:0] r_remain;
    logic [BURST_W-1:0] n_remain;
    logic [TICK_W-1:0]  r_ticks;
    logic [TICK_W-1:0]  n_ticks;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_out;
    t_result            n_out;

    t_cell_ctrl         w_ctrl;
    logic               w_gt    [QUEUE_DEPTH];
    t_entry             w_entry [QUEUE_DEPTH];
    logic               w_accept;
    logic               w_full;
    logic               w_take;
    logic               w_busy;
    logic [ID_W-1:0]    w_job;
    logic [BURST_W-1:0] w_left;

    assign i_job.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_job.valid && i_job.ready;
    assign w_full      = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign w_take      = !r_running && (r_count != '0);

    assign w_ctrl.insert    = w_accept && (i_job.operation == OP_ARRIVE) &&
                              (i_job.burst_len != '0) && !w_full;
    assign w_ctrl.pop       = w_accept && (i_job.operation == OP_TICK) && w_take;
    assign w_ctrl.new_entry = '{burst: i_job.burst_len, id: i_job.job_id};

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
            ljfs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_occ        (COUNT_W'(k) < r_count),
                .i_prev_gt    ((k == 0) ? 1'b0 : w_gt[(k == 0) ? 0 : k - 1]),
                .i_prev_entry ((k == 0) ? w_ctrl.new_entry : w_entry[(k == 0) ? 0 : k - 1]),
                .i_next_entry ((k == QUEUE_DEPTH - 1) ? w_ctrl.new_entry
                               : w_entry[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
                .o_gt         (w_gt[k]),
                .o_entry      (w_entry[k])
            );
        end
    endgenerate

    // Job in service for this tick, after an idle server picks up the head.
    assign w_busy = r_running || w_take;
    assign w_job  = w_take ? w_entry[0].id : r_run_job;
    assign w_left = w_take ? w_entry[0].burst : r_remain;

    always_comb begin
        n_count     = r_count;
        n_running   = r_running;
        n_run_job   = r_run_job;
        n_remain    = r_remain;
        n_ticks     = r_ticks;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.status = ST_OK;
            if (i_job.operation == OP_ARRIVE) begin
                if (i_job.burst_len == '0) begin
                    n_out.status = ST_ZERO;
                end else if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end else begin
                n_ticks = r_ticks + TICK_W'(1);
                if (w_take) begin
                    n_count = r_count - COUNT_W'(1);
                end
                if (w_busy) begin
                    n_out.slot_busy = 1'b1;
                    n_out.slot_job  = w_job;
                    n_run_job       = w_job;
                    n_remain        = (w_left != '0) ? w_left - BURST_W'(1) : w_left;
                    n_running       = 1'b1;
                    if (w_left <= BURST_W'(1)) begin
                        n_running         = 1'b0;
                        n_out.job_done    = 1'b1;
                        n_out.finish_tick = r_ticks + TICK_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_running   <= 1'b0;
            r_run_job   <= '0;
            r_remain    <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_running   <= n_running;
            r_run_job   <= n_run_job;
            r_remain    <= n_remain;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.slot_busy   = r_out.slot_busy;
    assign o_res.slot_job    = r_out.slot_job;
    assign o_res.job_done    = r_out.job_done;
    assign o_res.finish_tick = r_out.finish_tick;

    `LJFS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(QUEUE_DEPTH))
    `LJFS_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, r_out_valid && r_out.job_done, r_out.slot_busy)
    `LJFS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctrl.insert,
        r_count == $past(r_count) + COUNT_W'(1))
    `LJFS_ASSERT_NEXT(a_last_unit, i_clk, i_rst_n,
        w_accept && (i_job.operation == OP_TICK) && r_running && (r_remain == BURST_W'(1)),
        !r_running && r_out.job_done)

endmodule

`default_nettype wire
